@@ design/tccs_pkg.sv @@
// Shared types and constants for the text console cursor/scroll core.
// Used by tccs_ctrl, tccs_dpath and text_console_cursor_scroll_core; no dependencies.
package tccs_pkg;

  // Request opcodes
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Character codes and attribute defaults
  localparam int         CHAR_W       = 8;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_RETURN  = 8'd13;
  localparam logic [7:0] ATTR_RESET   = 8'd15;

  // Controller states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_PUT,
    ST_BLANK,
    ST_FILL,
    ST_READ,
    ST_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;     // latch the accepted request
    logic scroll;      // advance top row, park cursor on last row, arm row sweep
    logic newline;     // next row, column 0
    logic ret;         // column 0
    logic wrap;        // column 0, next row
    logic write_char;  // store character at cursor and advance column
    logic fill_start;  // home cursor and top row, arm whole-screen sweep
    logic sweep_step;  // blank one cell of the armed sweep
    logic sweep_rst;   // sweep uses the reset attribute
    logic load_out;    // load the result register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       row_ge;
    logic       col_ge;
    logic       is_nl;
    logic       is_cr;
    logic       sweep_last;
    logic       out_busy;
  } sts_t;

endpackage

@@ design/text_console_cursor_scroll_core.sv @@
// Top level of the character-cell text console with cursor and scroll.
// Depends on tccs_pkg, tccs_ctrl and tccs_dpath.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------------------
//  in_      | request   | in_valid/in_stall  | opcode, char_code, read_row, read_col
//  out_     | result    | out_valid/out_stall| cell_char, cell_attr, cursor_row, cursor_col
//  cfg_     | write     | cfg_wr_en          | wr_data (text attribute)
//
// One request at a time. Put and read go from decode through the put or read state to done,
// which loads the result; an unused opcode goes from decode straight to done. A put that wraps
// to the next row passes the put state again. A put that scrolls first blanks the COLUMNS cells of
// the new last row (rows rotate through a top-row pointer); a clear blanks all ROWS*COLUMNS
// cells, one cell per cycle through the RAM write port. After reset a clearing pass over all
// ROWS*COLUMNS cells runs before the first request is taken. A stalled result holds in the
// output register; the next request is still accepted and waits for that register to drain.
module text_console_cursor_scroll_core #(
  parameter int ROWS    = 25,
  parameter int COLUMNS = 80
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [7:0]                           cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_opcode,
  input  logic [7:0]                           in_char_code,
  input  logic [$clog2(ROWS + 1)-1:0]          in_read_row,
  input  logic [$clog2(COLUMNS + 1)-1:0]       in_read_col,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [7:0]                           out_cell_char,
  output logic [7:0]                           out_cell_attr,
  output logic [$clog2(ROWS + 1)-1:0]          out_cursor_row,
  output logic [$clog2(COLUMNS + 1)-1:0]       out_cursor_col
);

  tccs_pkg::cmd_t cmd;
  tccs_pkg::sts_t sts;

  // Sequencer
  tccs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Cursor, screen store and result register
  tccs_dpath #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_opcode      (in_opcode),
    .in_char_code   (in_char_code),
    .in_read_row    (in_read_row),
    .in_read_col    (in_read_col),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cell_char  (out_cell_char),
    .out_cell_attr  (out_cell_attr),
    .out_cursor_row (out_cursor_row),
    .out_cursor_col (out_cursor_col)
  );

endmodule

@@ design/tccs_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module tccs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/tccs_ctrl.sv @@
// Controller state machine for the text console core.
// Depends on tccs_pkg (state_t, cmd_t, sts_t, opcodes).
module tccs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  tccs_pkg::sts_t  sts,
  output tccs_pkg::cmd_t  cmd
);

  tccs_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tccs_pkg::ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      tccs_pkg::ST_INIT: begin
        cmd.sweep_step = 1'b1;
        cmd.sweep_rst  = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = tccs_pkg::ST_IDLE;
        end
      end
      tccs_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = tccs_pkg::ST_DECODE;
        end
      end
      tccs_pkg::ST_DECODE: begin
        unique case (sts.op)
          tccs_pkg::OP_PUT:  state_nxt = tccs_pkg::ST_PUT;
          tccs_pkg::OP_READ: state_nxt = tccs_pkg::ST_READ;
          tccs_pkg::OP_CLEAR: begin
            cmd.fill_start = 1'b1;
            state_nxt      = tccs_pkg::ST_FILL;
          end
          default:           state_nxt = tccs_pkg::ST_DONE;
        endcase
      end
      tccs_pkg::ST_PUT: begin
        // Scroll first, then act on the character; a wrap loops back here
        if (sts.row_ge) begin
          cmd.scroll = 1'b1;
          state_nxt  = tccs_pkg::ST_BLANK;
        end else if (sts.is_nl) begin
          cmd.newline = 1'b1;
          state_nxt   = tccs_pkg::ST_DONE;
        end else if (sts.is_cr) begin
          cmd.ret   = 1'b1;
          state_nxt = tccs_pkg::ST_DONE;
        end else if (sts.col_ge) begin
          cmd.wrap = 1'b1;
        end else begin
          cmd.write_char = 1'b1;
          state_nxt      = tccs_pkg::ST_DONE;
        end
      end
      tccs_pkg::ST_BLANK: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = tccs_pkg::ST_PUT;
        end
      end
      tccs_pkg::ST_FILL: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = tccs_pkg::ST_DONE;
        end
      end
      tccs_pkg::ST_READ: begin
        state_nxt = tccs_pkg::ST_DONE;
      end
      tccs_pkg::ST_DONE: begin
        // Hold until the result register is free
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = tccs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tccs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/tccs_dpath.sv @@
// Datapath of the text console core: cursor, top-row pointer, sweep counter,
// screen RAM and result register. Depends on tccs_pkg and tccs_ram.
module tccs_dpath #(
  parameter int ROWS    = 25,
  parameter int COLUMNS = 80,
  localparam int ROW_W  = $clog2(ROWS + 1),
  localparam int COL_W  = $clog2(COLUMNS + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tccs_pkg::cmd_t               cmd,
  output tccs_pkg::sts_t               sts,
  input  logic                         cfg_wr_en,
  input  logic [7:0]                   cfg_wr_data,
  input  logic [1:0]                   in_opcode,
  input  logic [tccs_pkg::CHAR_W-1:0]  in_char_code,
  input  logic [ROW_W-1:0]             in_read_row,
  input  logic [COL_W-1:0]             in_read_col,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tccs_pkg::CHAR_W-1:0]  out_cell_char,
  output logic [tccs_pkg::CHAR_W-1:0]  out_cell_attr,
  output logic [ROW_W-1:0]             out_cursor_row,
  output logic [COL_W-1:0]             out_cursor_col
);

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int RIDX_W = $clog2(ROWS);
  localparam int SUM_W  = ROW_W + 1;
  localparam int CELL_W = 2 * tccs_pkg::CHAR_W;
  localparam logic [ADDR_W-1:0] COLS_A = ADDR_W'(COLUMNS);

  // Request, cursor and configuration registers
  logic [1:0]                  op_r;
  logic [tccs_pkg::CHAR_W-1:0] char_r;
  logic [ROW_W-1:0]            rd_row_r;
  logic [COL_W-1:0]            rd_col_r;
  logic [ROW_W-1:0]            row_r, row_nxt;
  logic [COL_W-1:0]            col_r, col_nxt;
  logic [RIDX_W-1:0]           top_r, top_nxt;
  logic [7:0]                  attr_r;
  logic [ADDR_W-1:0]           sweep_addr_r, sweep_addr_nxt;
  logic [CNT_W-1:0]            sweep_left_r, sweep_left_nxt;
  logic                        out_valid_r;
  logic [tccs_pkg::CHAR_W-1:0] out_char_r, out_attr_r;
  logic [ROW_W-1:0]            out_row_r;
  logic [COL_W-1:0]            out_col_r;

  // Address path
  logic              is_read;
  logic [ROW_W-1:0]  row_sel;
  logic [COL_W-1:0]  col_sel;
  logic [SUM_W-1:0]  row_sum, row_wrap;
  logic [RIDX_W-1:0] phys_row, mul_row;
  logic [ADDR_W-1:0] row_base, cell_addr;
  logic              rd_ok;

  // RAM ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;
  logic [7:0]        blank_attr;

  // Map a logical row to its physical row through the top-row pointer
  assign is_read  = (op_r == tccs_pkg::OP_READ);
  assign row_sel  = is_read ? rd_row_r : row_r;
  assign col_sel  = is_read ? rd_col_r : col_r;
  assign row_sum  = {1'b0, row_sel} + SUM_W'(top_r);
  assign row_wrap = (row_sum >= SUM_W'(ROWS)) ? (row_sum - SUM_W'(ROWS)) : row_sum;
  assign phys_row = row_wrap[RIDX_W-1:0];
  assign mul_row  = cmd.scroll ? top_r : phys_row;
  assign row_base = ADDR_W'(mul_row) * COLS_A;
  assign cell_addr = row_base + ADDR_W'(col_sel);
  assign rd_ok    = (rd_row_r < ROW_W'(ROWS)) && (rd_col_r < COL_W'(COLUMNS));

  // Status to the controller
  assign sts.op         = op_r;
  assign sts.row_ge     = (row_r >= ROW_W'(ROWS));
  assign sts.col_ge     = (col_r >= COL_W'(COLUMNS));
  assign sts.is_nl      = (char_r == tccs_pkg::CHAR_NEWLINE);
  assign sts.is_cr      = (char_r == tccs_pkg::CHAR_RETURN);
  assign sts.sweep_last = (sweep_left_r == CNT_W'(1));
  assign sts.out_busy   = out_valid_r & out_stall;

  // Capture the request
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= in_opcode;
      char_r   <= in_char_code;
      rd_row_r <= in_read_row;
      rd_col_r <= in_read_col;
    end
  end

  // Cursor, top row and sweep next values
  always_comb begin
    row_nxt        = row_r;
    col_nxt        = col_r;
    top_nxt        = top_r;
    sweep_addr_nxt = sweep_addr_r;
    sweep_left_nxt = sweep_left_r;
    if (cmd.scroll) begin
      top_nxt        = (top_r == RIDX_W'(ROWS - 1)) ? '0 : top_r + RIDX_W'(1);
      row_nxt        = ROW_W'(ROWS - 1);
      col_nxt        = '0;
      sweep_addr_nxt = row_base;
      sweep_left_nxt = CNT_W'(COLUMNS);
    end else if (cmd.newline || cmd.wrap) begin
      row_nxt = row_r + ROW_W'(1);
      col_nxt = '0;
    end else if (cmd.ret) begin
      col_nxt = '0;
    end else if (cmd.write_char) begin
      col_nxt = col_r + COL_W'(1);
    end else if (cmd.fill_start) begin
      top_nxt        = '0;
      row_nxt        = '0;
      col_nxt        = '0;
      sweep_addr_nxt = '0;
      sweep_left_nxt = CNT_W'(CELLS);
    end else if (cmd.sweep_step) begin
      sweep_addr_nxt = sweep_addr_r + ADDR_W'(1);
      sweep_left_nxt = sweep_left_r - CNT_W'(1);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r        <= '0;
      col_r        <= '0;
      top_r        <= '0;
      attr_r       <= tccs_pkg::ATTR_RESET;
      sweep_addr_r <= '0;
      sweep_left_r <= CNT_W'(CELLS);
      out_valid_r  <= 1'b0;
    end else begin
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      top_r        <= top_nxt;
      sweep_addr_r <= sweep_addr_nxt;
      sweep_left_r <= sweep_left_nxt;
      if (cfg_wr_en) begin
        attr_r <= cfg_wr_data;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Screen store writes: a character at the cursor or a blank from the sweep
  assign blank_attr = cmd.sweep_rst ? tccs_pkg::ATTR_RESET : attr_r;
  assign ram_we     = cmd.write_char | cmd.sweep_step;
  assign ram_waddr  = cmd.write_char ? cell_addr : sweep_addr_r;
  assign ram_wdata  = cmd.write_char ? {attr_r, char_r}
                                     : {blank_attr, {tccs_pkg::CHAR_W{1'b0}}};

  tccs_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cell_addr),
    .rdata (ram_rdata)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (is_read && rd_ok) begin
        out_char_r <= ram_rdata[tccs_pkg::CHAR_W-1:0];
        out_attr_r <= ram_rdata[CELL_W-1:tccs_pkg::CHAR_W];
      end else begin
        out_char_r <= '0;
        out_attr_r <= '0;
      end
      out_row_r <= row_r;
      out_col_r <= col_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_char  = out_char_r;
  assign out_cell_attr  = out_attr_r;
  assign out_cursor_row = out_row_r;
  assign out_cursor_col = out_col_r;

endmodule
